FILE: rtl/pspd_pkg.sv
// Shared types and constants of the gain-scheduled PID speed controller.
package pspd_pkg;

  localparam int TARGET_W  = 11;
  localparam int MEAS_W    = 12;
  localparam int ERR_W     = 13;
  localparam int DIFF_W    = 14;
  localparam int GAIN_W    = 20;
  localparam int CFG_W     = 60;
  localparam int CFG_IDX_W = 3;
  localparam int DUTY_W    = 8;

  // shared multiplier: gain-sized operand times one chunk of a magnitude
  localparam int CHUNK_W = 24;
  localparam int PROD_W  = GAIN_W + CHUNK_W;

  // term limit 2^56 on the integral term; accumulator holds it plus the P and D terms with sign
  localparam int TERM_LIM_LOG2 = 56;
  localparam int TERM_W        = TERM_LIM_LOG2 + 1;
  localparam int ACC_W         = TERM_W + 1;

  // divide by 100 as multiply by reciprocal, exact for values below 2^15
  localparam int         W_W         = 15;
  localparam logic [GAIN_W-1:0] RECIP_100 = 20'd5243;
  localparam int         RECIP_SHIFT = 19;

  typedef logic [GAIN_W-1:0]  gain_t;
  typedef logic [CHUNK_W-1:0] chunk_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [TARGET_W-1:0] target_t;
  typedef logic [MEAS_W-1:0]  meas_t;
  typedef logic [DUTY_W-1:0]  duty_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_TARGET  = 3'd0,
    REG_MID_TARGET  = 3'd1,
    REG_LOW_GAINS   = 3'd2,
    REG_MID_GAINS   = 3'd3,
    REG_HIGH_GAINS  = 3'd4
  } cfg_reg_t;

endpackage

FILE: rtl/pspd_if.sv
// Valid/ready channel interfaces for speed samples and drive results.
interface pspd_in_if;
  import pspd_pkg::*;
  logic    valid;
  logic    ready;
  target_t set_speed;
  meas_t   measured_speed;
  modport source (output valid, output set_speed, output measured_speed, input ready);
  modport sink   (input valid, input set_speed, input measured_speed, output ready);
endinterface

interface pspd_out_if;
  import pspd_pkg::*;
  logic  valid;
  logic  ready;
  duty_t duty;
  logic  direction;
  logic  drive_updated;
  logic  sum_saturated;
  modport source (output valid, output duty, output direction, output drive_updated,
                  output sum_saturated, input ready);
  modport sink   (input valid, input duty, input direction, input drive_updated,
                  input sum_saturated, output ready);
endinterface

FILE: rtl/pspd_mul.sv
// Shared unsigned multiplier with registered product.
module pspd_mul (
  input  logic             clk,
  input  pspd_pkg::gain_t  a,
  input  pspd_pkg::chunk_t b,
  output pspd_pkg::prod_t  prod
);
  import pspd_pkg::*;

  prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

FILE: rtl/pid_speed_to_pwm_drive.sv
// Top level of the gain-scheduled PID speed controller with PWM drive output.
// Usage
//   in_bus  : one beat per control period, target speed (unsigned RPM) and
//             measured speed (two's complement RPM).
//   out_bus : one beat per input beat: held duty, direction, a flag that the
//             drive was rewritten and a flag that the error sum clamped.
//   cfg_*   : plain write port; targets and packed Kp/Ki/Kd gain sets.
//             Write only while the block is idle.
// Timing
//   A single 20x24 multiplier is stepped through Kp*e, Kd*d and the two
//   halves of Ki*sum, then reused for the divide-by-100 reciprocal. The
//   result beat is loaded into the output register from the final step; a
//   new input beat is taken only once the sequencer is back in idle.
//   in_bus.ready is high only while the sequencer is idle.
// Reset: synchronous, active low; targets go to 30/60, gains to zero, error
//   sum, last error, held duty and direction to zero.
// Stall
//   The result waits in its output register; the sequencer holds in its
//   final step until that register is free, and the next input beat may be
//   taken while an earlier result is still waiting.
module pid_speed_to_pwm_drive #(
  parameter int GAIN_FRAC_BITS = 18,
  parameter int SUM_WIDTH      = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pspd_in_if.sink                             in_bus,
  pspd_out_if.source                          out_bus,
  input  logic                                cfg_we,
  input  logic [pspd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pspd_pkg::CFG_W-1:0]          cfg_data
);
  import pspd_pkg::*;

  localparam int SPAD_W = 2 * CHUNK_W;          // padded sum magnitude
  localparam int MLOW_W = GAIN_FRAC_BITS + 7;   // at or above this the duty is saturated
  localparam int M255_W = MLOW_W + 8;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [TERM_W-1:0]    TERM_LIM = TERM_W'(1) << TERM_LIM_LOG2;

  // one-hot sequencer
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_PE   = 11'b000_0000_0010,  // issue Kp*|e|
    S_PD   = 11'b000_0000_0100,  // issue Kd*|d|, take Kp term
    S_IL   = 11'b000_0000_1000,  // issue Ki*sum low, take Kd term
    S_IH   = 11'b000_0001_0000,  // issue Ki*sum high, hold low part
    S_IS   = 11'b000_0010_0000,  // join halves, clamp at 2^56
    S_ACC  = 11'b000_0100_0000,  // add integral term
    S_MAG  = 11'b000_1000_0000,  // magnitude and sign of u
    S_W    = 11'b001_0000_0000,  // |u|*255 >> frac
    S_Q    = 11'b010_0000_0000,  // issue /100 reciprocal
    S_OUT  = 11'b100_0000_0000   // duty, load result register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  target_t            low_target_r, mid_target_r;
  logic [CFG_W-1:0]   low_gains_r, mid_gains_r, high_gains_r;

  // controller state
  logic [SUM_WIDTH-1:0] error_sum_r;
  logic [ERR_W-1:0]     last_error_r;
  duty_t                held_duty_r;
  logic                 held_dir_r;

  // per-item working registers
  gain_t                kp_r, ki_r, kd_r;
  logic [ERR_W-1:0]     e_mag_r;
  logic                 e_neg_r;
  logic [DIFF_W-1:0]    d_mag_r;
  logic                 d_neg_r;
  logic [SPAD_W-1:0]    s_mag_r;
  logic                 s_neg_r;
  logic                 sat_r;
  logic [TERM_W-1:0]    term_r, term_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 u_zero_r, u_neg_r, big_r;
  logic [MLOW_W-1:0]    m_low_r;
  logic [W_W-1:0]       w_r;

  // result register
  logic                 out_valid_r;
  duty_t                out_duty_r;
  logic                 out_dir_r, out_upd_r, out_sat_r;

  // shared multiplier
  gain_t  mul_a;
  chunk_t mul_b;
  prod_t  prod;

  pspd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ---------------------------------------------------------------- front end
  logic                 in_acc;
  logic [ERR_W-1:0]     e_w;
  logic [DIFF_W-1:0]    d_w;
  logic [SUM_WIDTH:0]   s_ext;
  logic [SUM_WIDTH-1:0] s_w;
  logic                 s_sat;
  logic [CFG_W-1:0]     gains_sel;

  assign in_acc = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);

  always_comb begin
    e_w   = ERR_W'({2'b00, in_bus.set_speed})
          - ERR_W'({in_bus.measured_speed[MEAS_W-1], in_bus.measured_speed});
    d_w   = DIFF_W'({e_w[ERR_W-1], e_w}) - DIFF_W'({last_error_r[ERR_W-1], last_error_r});
    s_ext = {error_sum_r[SUM_WIDTH-1], error_sum_r}
          + {{(SUM_WIDTH+1-ERR_W){e_w[ERR_W-1]}}, e_w};
    // overflow when the two top bits disagree
    s_sat = s_ext[SUM_WIDTH] != s_ext[SUM_WIDTH-1];
    if (s_sat) begin
      s_w = s_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      s_w = s_ext[SUM_WIDTH-1:0];
    end
    // low target wins when both match
    if (in_bus.set_speed == low_target_r) begin
      gains_sel = low_gains_r;
    end else if (in_bus.set_speed == mid_target_r) begin
      gains_sel = mid_gains_r;
    end else begin
      gains_sel = high_gains_r;
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [TERM_W-1:0]  ih_sum;
  logic               ih_big;
  logic [ACC_W-1:0]   add_val, add_twos;
  logic               add_neg;
  logic [ACC_W-1:0]   u_mag;
  logic [M255_W-1:0]  m255;
  logic [8:0]         q;
  duty_t              duty_calc;
  logic               out_free;

  always_comb begin
    mul_a    = RECIP_100;
    mul_b    = CHUNK_W'(w_r);
    add_val  = ACC_W'(prod);
    add_neg  = 1'b0;
    case (state_r)
      S_PE: begin
        mul_a = kp_r;
        mul_b = CHUNK_W'(e_mag_r);
      end
      S_PD: begin
        mul_a   = kd_r;
        mul_b   = CHUNK_W'(d_mag_r);
        add_neg = e_neg_r;
      end
      S_IL: begin
        mul_a   = ki_r;
        mul_b   = s_mag_r[CHUNK_W-1:0];
        add_neg = d_neg_r;
      end
      S_IH: begin
        mul_a = ki_r;
        mul_b = s_mag_r[SPAD_W-1:CHUNK_W];
      end
      S_ACC: begin
        add_val = ACC_W'(term_r);
        add_neg = s_neg_r;
      end
      default: begin
      end
    endcase
    add_twos = add_neg ? (~add_val + ACC_W'(1)) : add_val;
  end

  always_comb begin
    // high half weighs 2^24; anything at or above 2^32 there reaches the limit
    ih_big = |prod[PROD_W-1:32];
    ih_sum = TERM_W'({prod[31:0], {CHUNK_W{1'b0}}}) + term_r;
    term_nxt = term_r;
    if (state_r == S_IH) begin
      term_nxt = TERM_W'(prod);
    end else if (state_r == S_IS) begin
      term_nxt = (ih_big || ih_sum > TERM_LIM) ? TERM_LIM : ih_sum;
    end

    acc_nxt = acc_r;
    case (state_r)
      S_PD:            acc_nxt = add_twos;
      S_IL, S_ACC:     acc_nxt = acc_r + add_twos;
      default:         acc_nxt = acc_r;
    endcase

    u_mag = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;
    m255  = {m_low_r, 8'h00} - M255_W'(m_low_r);
    q     = prod[RECIP_SHIFT+8:RECIP_SHIFT];

    if (big_r || q[8]) begin
      duty_calc = 8'hFF;
    end else if (q == 9'd0) begin
      duty_calc = 8'h01;
    end else begin
      duty_calc = q[7:0];
    end
    out_free = !out_valid_r || out_bus.ready;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) begin
        state_nxt = S_PE;
      end
      S_PE:    state_nxt = S_PD;
      S_PD:    state_nxt = S_IL;
      S_IL:    state_nxt = S_IH;
      S_IH:    state_nxt = S_IS;
      S_IS:    state_nxt = S_ACC;
      S_ACC:   state_nxt = S_MAG;
      S_MAG:   state_nxt = S_W;
      S_W:     state_nxt = S_Q;
      S_Q:     state_nxt = S_OUT;
      S_OUT:   if (out_free) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      low_target_r <= TARGET_W'(30);
      mid_target_r <= TARGET_W'(60);
      low_gains_r  <= '0;
      mid_gains_r  <= '0;
      high_gains_r <= '0;
      error_sum_r  <= '0;
      last_error_r <= '0;
      held_duty_r  <= '0;
      held_dir_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_TARGET: low_target_r <= cfg_data[TARGET_W-1:0];
          REG_MID_TARGET: mid_target_r <= cfg_data[TARGET_W-1:0];
          REG_LOW_GAINS:  low_gains_r  <= cfg_data;
          REG_MID_GAINS:  mid_gains_r  <= cfg_data;
          REG_HIGH_GAINS: high_gains_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        error_sum_r  <= s_w;
        last_error_r <= e_w;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        if (!u_zero_r) begin
          held_duty_r <= duty_calc;
          held_dir_r  <= u_neg_r;
        end
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kp_r    <= gains_sel[GAIN_W-1:0];
      ki_r    <= gains_sel[2*GAIN_W-1:GAIN_W];
      kd_r    <= gains_sel[3*GAIN_W-1:2*GAIN_W];
      e_neg_r <= e_w[ERR_W-1];
      e_mag_r <= e_w[ERR_W-1] ? (~e_w + ERR_W'(1)) : e_w;
      d_neg_r <= d_w[DIFF_W-1];
      d_mag_r <= d_w[DIFF_W-1] ? (~d_w + DIFF_W'(1)) : d_w;
      s_neg_r <= s_w[SUM_WIDTH-1];
      s_mag_r <= SPAD_W'(s_w[SUM_WIDTH-1] ? SUM_WIDTH'(~s_w + SUM_WIDTH'(1)) : s_w);
      sat_r   <= s_sat;
    end
    term_r <= term_nxt;
    acc_r  <= acc_nxt;
    if (state_r == S_MAG) begin
      u_zero_r <= (acc_r == '0);
      u_neg_r  <= acc_r[ACC_W-1];
      big_r    <= |u_mag[ACC_W-1:MLOW_W];
      m_low_r  <= u_mag[MLOW_W-1:0];
    end
    if (state_r == S_W) begin
      w_r <= m255[GAIN_FRAC_BITS+W_W-1:GAIN_FRAC_BITS];
    end
    if (state_r == S_OUT && out_free) begin
      out_duty_r <= u_zero_r ? held_duty_r : duty_calc;
      out_dir_r  <= u_zero_r ? held_dir_r : u_neg_r;
      out_upd_r  <= !u_zero_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.duty          = out_duty_r;
  assign out_bus.direction     = out_dir_r;
  assign out_bus.drive_updated = out_upd_r;
  assign out_bus.sum_saturated = out_sat_r;

  // ---------------------------------------------------------------- checks
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && sat_r) |-> (error_sum_r == SUM_MAX || error_sum_r == SUM_MIN))
    else $error("saturation flag without clamped error sum");

  a_duty_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free && !u_zero_r) |=> (held_duty_r != '0))
    else $error("drive update left duty at zero");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result beat not loaded");

  a_term_limited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (term_r <= TERM_LIM))
    else $error("integral term past its limit");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for the gain-scheduled PID speed controller and its PWM drive output.
module testbench;
  import pspd_pkg::*;

  localparam int FRAC_BITS   = 18;
  localparam int SUM_BITS    = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 105;
  localparam logic [127:0] TERM_CAP = 128'd1 << 56;

  typedef struct {
    duty_t duty;
    logic  direction;
    logic  drive_updated;
    logic  sum_saturated;
  } drive_beat_t;

  // Tracks controller state, predicts each drive beat and checks what the block sends.
  class drive_scoreboard;
    target_t          low_tgt, mid_tgt;
    logic [CFG_W-1:0] low_set, mid_set, high_set;
    longint           err_sum, last_err;
    duty_t            held_duty;
    logic             held_dir;
    drive_beat_t      drive_q[$];
    int               mismatches, samples, checked, rewrites, clamps;

    function new();
      low_tgt    = 11'd30;
      mid_tgt    = 11'd60;
      low_set    = '0;
      mid_set    = '0;
      high_set   = '0;
      err_sum    = 0;
      last_err   = 0;
      held_duty  = '0;
      held_dir   = 1'b0;
      mismatches = 0;
      samples    = 0;
      checked    = 0;
      rewrites   = 0;
      clamps     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_LOW_TARGET: low_tgt = val[TARGET_W-1:0];
        REG_MID_TARGET: mid_tgt = val[TARGET_W-1:0];
        REG_LOW_GAINS:  low_set = val;
        REG_MID_GAINS:  mid_set = val;
        REG_HIGH_GAINS: high_set = val;
        default: ;
      endcase
    endfunction

    // gain * v, magnitude held at 2^56
    function longint gain_term(longint gain, longint v);
      logic [127:0] p;
      p = 128'(gain) * 128'((v < 0) ? -v : v);
      if (p > TERM_CAP) p = TERM_CAP;
      return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function void predict_drive(target_t tgt, meas_t meas);
      logic [CFG_W-1:0] g;
      longint           kp, ki, kd, e, d, s, smax, smin, u;
      logic [127:0]     mag;
      drive_beat_t      r;
      if (tgt == low_tgt) g = low_set;
      else if (tgt == mid_tgt) g = mid_set;
      else g = high_set;
      kp = longint'(g[GAIN_W-1:0]);
      ki = longint'(g[2*GAIN_W-1:GAIN_W]);
      kd = longint'(g[3*GAIN_W-1:2*GAIN_W]);
      e  = longint'(tgt) - longint'($signed(meas));
      d  = e - last_err;
      smax = (longint'(1) <<< (SUM_BITS - 1)) - 1;
      smin = -smax - 1;
      s = err_sum + e;
      r.sum_saturated = 1'b0;
      if (s > smax) begin
        s = smax;
        r.sum_saturated = 1'b1;
      end
      if (s < smin) begin
        s = smin;
        r.sum_saturated = 1'b1;
      end
      err_sum = s;
      u = gain_term(kp, e) + gain_term(ki, s) + gain_term(kd, d);
      r.drive_updated = 1'b0;
      if (u != 0) begin
        mag = (u < 0) ? 128'(-u) : 128'(u);
        if (mag > TERM_CAP) mag = TERM_CAP;
        mag = (mag * 255) / (128'd100 << FRAC_BITS);
        if (mag > 255) mag = 255;
        else if (mag < 1) mag = 1;
        held_duty = duty_t'(mag);
        held_dir  = (u < 0);
        r.drive_updated = 1'b1;
        rewrites++;
      end
      last_err = e;
      if (r.sum_saturated) clamps++;
      r.duty      = held_duty;
      r.direction = held_dir;
      drive_q.push_back(r);
      samples++;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_drive(drive_beat_t got);
      drive_beat_t want;
      if (drive_q.size() == 0) begin
        flag($sformatf("drive beat with nothing predicted: duty=%0d dir=%0b upd=%0b sat=%0b",
                       got.duty, got.direction, got.drive_updated, got.sum_saturated));
        return;
      end
      want = drive_q.pop_front();
      if (got.duty !== want.duty || got.direction !== want.direction ||
          got.drive_updated !== want.drive_updated || got.sum_saturated !== want.sum_saturated)
        flag($sformatf("beat %0d: want duty=%0d dir=%0b upd=%0b sat=%0b, got duty=%0d dir=%0b upd=%0b sat=%0b",
                       checked, want.duty, want.direction, want.drive_updated, want.sum_saturated,
                       got.duty, got.direction, got.drive_updated, got.sum_saturated));
      checked++;
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  bit                   no_idle = 1'b0;   // both sides run flat out while set
  int                   cycle_count = 0;
  int                   settings_run = 1; // reset values count as the first setting
  drive_scoreboard      sb = new();

  pspd_in_if  in_ch ();
  pspd_out_if out_ch ();

  pid_speed_to_pwm_drive #(
    .GAIN_FRAC_BITS (FRAC_BITS),
    .SUM_WIDTH      (SUM_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[pid_speed_to_pwm_drive] ERROR");
      $finish;
    end
  end

  // One speed beat. valid is only dropped when a gap is drawn, so back-to-back
  // beats never see valid lowered and raised in the same step.
  task automatic send_sample(input target_t tgt, input meas_t meas);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.set_speed      <= tgt;
    in_ch.measured_speed <= meas;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_drive(tgt, meas);
  endtask

  // Register write lands at the edge after the drive; cfg_we is lowered by the caller.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Drop valid, let every predicted beat come back, then a short hold-off.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Full register set, plus a write to an index past the list that must change nothing.
  task automatic load_config(input logic [CFG_W-1:0] low_word, input logic [CFG_W-1:0] mid_word,
                             input logic [CFG_W-1:0] lo_g, input logic [CFG_W-1:0] mid_g,
                             input logic [CFG_W-1:0] hi_g);
    put_reg(CFG_IDX_W'(REG_HIGH_GAINS + $urandom_range(1, 3)), CFG_W'({$urandom, $urandom}));
    put_reg(REG_LOW_TARGET, low_word);
    put_reg(REG_MID_TARGET, mid_word);
    put_reg(REG_LOW_GAINS, lo_g);
    put_reg(REG_MID_GAINS, mid_g);
    put_reg(REG_HIGH_GAINS, hi_g);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // style 0: every gain at full scale, 1: all zero, otherwise a random mix that
  // leans towards small gains so the duty lands inside its range.
  function automatic gain_t pick_gain(int style);
    case (style)
      0: return '1;
      1: return '0;
      default: begin
        case ($urandom_range(0, 3))
          0: return gain_t'($urandom_range(0, 1023));
          1: return gain_t'($urandom_range(0, 1 << 19));
          2: return gain_t'($urandom);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Result side: ready is only lowered for a drawn stall, so a zero stall keeps
  // it high across consecutive beats.
  initial begin : result_sink
    int          stall;
    drive_beat_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.duty          = out_ch.duty;
      got.direction     = out_ch.direction;
      got.drive_updated = out_ch.drive_updated;
      got.sum_saturated = out_ch.sum_saturated;
      sb.check_drive(got);
    end
  end

  initial begin : stimulus
    int               p, pick, lean, off, mag_i, style, idle_free;
    target_t          tgt;
    meas_t            meas;
    logic [CFG_W-1:0] lw, mw;

    idle_free            = 0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_LOW_TARGET;
    cfg_data             <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.set_speed      <= '0;
    in_ch.measured_speed <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // Reset gains are zero: control stays zero, duty holds at 0 before any rewrite,
    // while the error sum still moves. Field extremes on both inputs.
    send_sample(11'd0, 12'sd0);
    send_sample(11'd2047, -12'sd2048);
    send_sample(11'd30, 12'sd2047);
    send_sample(11'd60, -12'sd1);
    settle();

    // Tiny Kp on the low target, unity Kp on mid, full-scale gains elsewhere.
    load_config(60'd100, 60'd200, 60'd1, 60'h40000, '1);
    send_sample(11'd100, 12'sd99);    // |u| below one duty step: floor gives 1
    send_sample(11'd100, 12'sd100);   // zero control after a rewrite: duty held
    send_sample(11'd200, 12'sd190);   // mid-range duty, clockwise
    send_sample(11'd200, 12'sd210);   // same magnitude, counter-clockwise
    repeat (9) send_sample(11'd2047, -12'sd2048); // duty pinned at 255, sum climbs fast
    send_sample(11'd0, 12'sd2047);
    settle();

    // Both targets equal: the low set must win. Junk above bit 10 of the target word.
    load_config(60'hABC_0000_0000_01F4, 60'd500, 60'h40000, '1, '0);
    send_sample(11'd500, 12'sd490);
    send_sample(11'd501, 12'sd0);
    send_sample(11'd2047, 12'sd2047);
    send_sample(11'd0, -12'sd2048);
    settle();

    // --- random phases ---
    for (p = 0; p < PHASES; p++) begin
      style = (p < 2) ? p : 2;
      if (style == 0) begin
        lw = CFG_W'(0);
        mw = CFG_W'(2047);
      end else if (style == 1) begin
        lw = CFG_W'(2047);
        mw = CFG_W'(0);
      end else begin
        lw = CFG_W'({$urandom, $urandom});
        mw = ($urandom_range(0, 5) == 0) ? lw : CFG_W'({$urandom, $urandom});
      end
      load_config(lw, mw,
                  {pick_gain(style), pick_gain(style), pick_gain(style)},
                  {pick_gain(style), pick_gain(style), pick_gain(style)},
                  {pick_gain(style), pick_gain(style), pick_gain(style)});
      no_idle = (p % 3 == 2);
      if (no_idle) idle_free++;
      // Even phases push the sum up, odd ones down, so it swings both ways.
      lean = (p % 2 == 0) ? 1 : -1;
      repeat (PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // tracking near the set point, mostly on the scheduled targets
          case ($urandom_range(0, 2))
            0: tgt = sb.low_tgt;
            1: tgt = sb.mid_tgt;
            default: tgt = target_t'($urandom);
          endcase
          off  = $urandom_range(0, 80);
          off  = off - 40;
          meas = meas_t'(int'(tgt) + off);
        end else if (pick < 65) begin
          tgt  = target_t'($urandom);
          meas = meas_t'($urandom);
        end else if (lean > 0) begin
          tgt   = target_t'($urandom_range(1800, 2047));
          mag_i = $urandom_range(1800, 2048);
          meas  = meas_t'(-mag_i);
        end else begin
          tgt  = target_t'($urandom_range(0, 200));
          meas = meas_t'($urandom_range(1850, 2047));
        end
        send_sample(tgt, meas);
      end
      settle();
      no_idle = 1'b0;
    end

    // Tail: anything the block still sends now has no prediction and gets flagged.
    repeat (24) @(posedge clk);
    $display("Covered %0d speed beats over %0d register settings (%0d without idling):",
             sb.samples, settings_run, idle_free);
    $display("  %0d drive rewrites, %0d sum clamps, %0d beats checked, %0d mismatches.",
             sb.rewrites, sb.clamps, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[pid_speed_to_pwm_drive] OK");
    end else begin
      $display("[pid_speed_to_pwm_drive] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pspd_pkg.sv
rtl/pspd_if.sv
rtl/pspd_mul.sv
rtl/pid_speed_to_pwm_drive.sv
tb/sv/testbench.sv
